FILE: src/pl0ts_pkg.sv
// ----------------------------------------------------------------------------
// pl0ts_pkg
// Shared types, token codes, character codes and keyword table for the
// PL/0 token scanner.
// ----------------------------------------------------------------------------
package pl0ts_pkg;

    // sizes
    localparam int IDENT_MAX_CHARS   = 10;  // 6 .. 10
    localparam int NUMBER_MAX_DIGITS = 14;  // 1 .. 14
    localparam int IDENT_HEAD_CHARS  = 5;
    localparam int IDENT_TAIL_CHARS  = IDENT_MAX_CHARS - IDENT_HEAD_CHARS;
    localparam int ICNT_W            = $clog2(IDENT_MAX_CHARS + 1);
    localparam int IDX_W             = $clog2(IDENT_MAX_CHARS);
    localparam int DCNT_W            = $clog2(NUMBER_MAX_DIGITS + 2);
    localparam int VALUE_W           = 47;

    // token codes
    localparam logic [5:0] TK_NUL     = 6'd0;
    localparam logic [5:0] TK_IDENT   = 6'd1;
    localparam logic [5:0] TK_NUMBER  = 6'd2;
    localparam logic [5:0] TK_PLUS    = 6'd3;
    localparam logic [5:0] TK_MINUS   = 6'd4;
    localparam logic [5:0] TK_TIMES   = 6'd5;
    localparam logic [5:0] TK_SLASH   = 6'd6;
    localparam logic [5:0] TK_EQL     = 6'd7;
    localparam logic [5:0] TK_NEQ     = 6'd8;
    localparam logic [5:0] TK_LSS     = 6'd9;
    localparam logic [5:0] TK_LEQ     = 6'd10;
    localparam logic [5:0] TK_GTR     = 6'd11;
    localparam logic [5:0] TK_GEQ     = 6'd12;
    localparam logic [5:0] TK_LPAREN  = 6'd13;
    localparam logic [5:0] TK_RPAREN  = 6'd14;
    localparam logic [5:0] TK_SEMI    = 6'd15;
    localparam logic [5:0] TK_PERIOD  = 6'd16;
    localparam logic [5:0] TK_BECOMES = 6'd17;
    localparam logic [5:0] TK_IF      = 6'd18;
    localparam logic [5:0] TK_ELSE    = 6'd19;
    localparam logic [5:0] TK_WHILE   = 6'd20;
    localparam logic [5:0] TK_PRINT   = 6'd21;
    localparam logic [5:0] TK_READ    = 6'd22;
    localparam logic [5:0] TK_CALL    = 6'd24;
    localparam logic [5:0] TK_VAR     = 6'd25;
    localparam logic [5:0] TK_FUNC    = 6'd26;
    localparam logic [5:0] TK_FOR     = 6'd27;
    localparam logic [5:0] TK_IN      = 6'd28;
    localparam logic [5:0] TK_LBRACE  = 6'd29;
    localparam logic [5:0] TK_RBRACE  = 6'd30;
    localparam logic [5:0] TK_MOD     = 6'd31;
    localparam logic [5:0] TK_ADD     = 6'd32;
    localparam logic [5:0] TK_SUB     = 6'd33;
    localparam logic [5:0] TK_CONST   = 6'd34;
    localparam logic [5:0] TK_ODD     = 6'd35;
    localparam logic [5:0] TK_REPEAT  = 6'd36;
    localparam logic [5:0] TK_CHAR    = 6'd37;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5A;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LZ      = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // keyword table, words right-justified
    localparam int KW_COUNT   = 14;
    localparam int KW_MAX_LEN = 6;

    localparam logic [8*KW_MAX_LEN-1:0] KW_WORD [KW_COUNT] = '{
        "call", "const", "else", "for", "func", "if", "in", "odd",
        "print", "read", "repeat", "var", "while", "char"
    };
    localparam int KW_LEN [KW_COUNT] = '{4, 5, 4, 3, 4, 2, 2, 3, 5, 4, 6, 3, 5, 4};
    localparam logic [5:0] KW_CODE [KW_COUNT] = '{
        TK_CALL, TK_CONST, TK_ELSE, TK_FOR, TK_FUNC, TK_IF, TK_IN, TK_ODD,
        TK_PRINT, TK_READ, TK_REPEAT, TK_VAR, TK_WHILE, TK_CHAR
    };

    typedef logic [IDENT_MAX_CHARS-1:0][7:0] t_ident_chars;

    typedef struct packed {
        logic [5:0]         code;
        logic [VALUE_W-1:0] value;
        logic               too_long;
        logic [39:0]        head;
        logic [39:0]        tail;
        logic [3:0]         length;
        logic               last;
    } t_token;

    // tokens caused by one character
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_tok_pair;

    function automatic logic [VALUE_W-1:0] pow10_minus1(input int digits);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < digits; i++) begin
            p = p * 64'd10;
        end
        return VALUE_W'(p - 64'd1);
    endfunction

    localparam logic [VALUE_W-1:0] NUM_SAT = pow10_minus1(NUMBER_MAX_DIGITS);

    function automatic t_token simple_token(input logic [5:0] code);
        t_token t;
        t      = '0;
        t.code = code;
        return t;
    endfunction

    // {hit, code}
    function automatic logic [6:0] kw_lookup(input t_ident_chars ch,
                                             input logic [ICNT_W-1:0] len);
        logic                    hit;
        logic [5:0]              code;
        logic                    eq;
        logic [8*KW_MAX_LEN-1:0] w;
        hit  = 1'b0;
        code = TK_NUL;
        for (int k = 0; k < KW_COUNT; k++) begin
            eq = (int'(len) == KW_LEN[k]);
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                w = KW_WORD[k] >> (8 * (KW_LEN[k] - 1 - i));
                if (i < KW_LEN[k] && ch[i] != w[7:0]) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                hit  = 1'b1;
                code = KW_CODE[k];
            end
        end
        return {hit, code};
    endfunction

    function automatic t_token ident_token(input t_ident_chars ch,
                                           input logic [ICNT_W-1:0] len);
        t_token     t;
        logic [6:0] kw;
        kw = kw_lookup(ch, len);
        t  = '0;
        if (kw[6]) begin
            t.code = kw[5:0];
        end else begin
            t.code   = TK_IDENT;
            t.length = 4'(len);
            for (int i = 0; i < IDENT_HEAD_CHARS; i++) begin
                if (int'(len) > i) begin
                    t.head[8*(IDENT_HEAD_CHARS-1-i) +: 8] = ch[i];
                end
            end
            for (int i = 0; i < IDENT_TAIL_CHARS; i++) begin
                if (int'(len) > IDENT_HEAD_CHARS + i) begin
                    t.tail[8*(IDENT_HEAD_CHARS-1-i) +: 8] = ch[IDENT_HEAD_CHARS + i];
                end
            end
        end
        return t;
    endfunction

endpackage

FILE: src/pl0ts_core.sv
// ----------------------------------------------------------------------------
// pl0ts_core
// Scanner state machine: classifies the offered character against the
// current mode and gives the zero, one or two tokens that it causes.
// ----------------------------------------------------------------------------
module pl0ts_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_char,
    input  logic                 i_take,
    output pl0ts_pkg::t_tok_pair o_toks
);
    import pl0ts_pkg::*;

    typedef enum logic [3:0] {
        M_START, M_IDENT, M_NUMBER, M_LT, M_GT, M_EQ, M_BANG,
        M_SLASH, M_PLUS, M_MINUS, M_LINE, M_BLOCK
    } t_mode;

    t_mode               r_mode,        n_mode;
    logic [ICNT_W-1:0]   r_ident_count, n_ident_count;
    logic [VALUE_W-1:0]  r_acc,         n_acc;
    logic [DCNT_W-1:0]   r_dcount,      n_dcount;
    logic                r_star,        n_star;
    t_ident_chars        r_chars;

    logic                is_letter, is_digit, is_alnum, is_space;
    logic [3:0]          digit;
    logic                st_emit;
    logic [5:0]          st_code;
    t_mode               st_mode;
    logic [7:0]          p_second;
    logic [5:0]          p_both, p_lone;
    logic                f_emit;
    t_token              f_tok;
    logic                run_start;
    logic                chr_we;
    logic [IDX_W-1:0]    chr_idx;
    t_ident_chars        m_chars;
    logic [ICNT_W-1:0]   ext_cnt, id_cnt;
    t_token              id_tok, num_tok, st_tok;

    assign is_letter = (i_char >= CH_LA && i_char <= CH_LZ) ||
                       (i_char >= CH_UA && i_char <= CH_UZ);
    assign is_digit  = (i_char >= CH_0 && i_char <= CH_9);
    assign is_alnum  = is_letter || is_digit;
    assign is_space  = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_LF);
    assign digit     = i_char[3:0];

    // scan from the start state
    always_comb begin
        st_emit = 1'b0;
        st_code = TK_NUL;
        st_mode = M_START;
        priority if (is_space) begin
            st_emit = 1'b0;
        end else if (i_char == CH_DOLLAR) begin
            st_emit = 1'b1;
            st_code = TK_PERIOD;
        end else if (is_letter) begin
            st_mode = M_IDENT;
        end else if (is_digit) begin
            st_mode = M_NUMBER;
        end else begin
            unique case (i_char)
                CH_LT:      st_mode = M_LT;
                CH_GT:      st_mode = M_GT;
                CH_EQ:      st_mode = M_EQ;
                CH_BANG:    st_mode = M_BANG;
                CH_SLASH:   st_mode = M_SLASH;
                CH_PLUS:    st_mode = M_PLUS;
                CH_MINUS:   st_mode = M_MINUS;
                CH_PERCENT: begin st_emit = 1'b1; st_code = TK_MOD;    end
                CH_STAR:    begin st_emit = 1'b1; st_code = TK_TIMES;  end
                CH_LPAREN:  begin st_emit = 1'b1; st_code = TK_LPAREN; end
                CH_RPAREN:  begin st_emit = 1'b1; st_code = TK_RPAREN; end
                CH_LBRACE:  begin st_emit = 1'b1; st_code = TK_LBRACE; end
                CH_RBRACE:  begin st_emit = 1'b1; st_code = TK_RBRACE; end
                CH_SEMI:    begin st_emit = 1'b1; st_code = TK_SEMI;   end
                default:    begin st_emit = 1'b1; st_code = TK_NUL;    end
            endcase
        end
    end

    assign st_tok = simple_token(st_code);

    // two-character operators: completing char, pair code, lone code
    always_comb begin
        p_second = CH_EQ;
        p_both   = TK_NUL;
        p_lone   = TK_NUL;
        unique case (r_mode)
            M_LT:    begin p_both = TK_LEQ; p_lone = TK_LSS;     end
            M_GT:    begin p_both = TK_GEQ; p_lone = TK_GTR;     end
            M_EQ:    begin p_both = TK_EQL; p_lone = TK_BECOMES; end
            M_BANG:  begin p_both = TK_NEQ; p_lone = TK_NUL;     end
            M_PLUS:  begin p_second = CH_PLUS;  p_both = TK_ADD; p_lone = TK_PLUS;  end
            M_MINUS: begin p_second = CH_MINUS; p_both = TK_SUB; p_lone = TK_MINUS; end
            default: p_second = CH_EQ;
        endcase
    end

    // identifier seen with the extending character in place
    always_comb begin
        m_chars = r_chars;
        if (r_mode == M_IDENT && is_alnum) begin
            m_chars[r_ident_count[IDX_W-1:0]] = i_char;
        end
    end

    assign ext_cnt = r_ident_count + 1'b1;
    assign id_cnt  = is_alnum ? ext_cnt : r_ident_count;
    assign id_tok  = ident_token(m_chars, id_cnt);

    always_comb begin
        num_tok      = simple_token(TK_NUMBER);
        num_tok.value = r_acc;
        if (r_dcount > DCNT_W'(NUMBER_MAX_DIGITS)) begin
            num_tok.value    = NUM_SAT;
            num_tok.too_long = 1'b1;
        end
    end

    always_comb begin
        n_mode        = r_mode;
        n_ident_count = r_ident_count;
        n_acc         = r_acc;
        n_dcount      = r_dcount;
        n_star        = r_star;
        f_emit        = 1'b0;
        f_tok         = id_tok;
        run_start     = 1'b0;
        chr_we        = 1'b0;
        chr_idx       = r_ident_count[IDX_W-1:0];

        unique case (r_mode)
            M_IDENT: begin
                if (is_alnum) begin
                    chr_we        = 1'b1;
                    n_ident_count = ext_cnt;
                    if (ext_cnt >= ICNT_W'(IDENT_MAX_CHARS)) begin
                        f_emit = 1'b1;
                        n_mode = M_START;
                    end
                end else begin
                    f_emit    = 1'b1;
                    run_start = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit) begin
                    if (r_dcount < DCNT_W'(NUMBER_MAX_DIGITS)) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + VALUE_W'(digit);
                    end
                    if (r_dcount <= DCNT_W'(NUMBER_MAX_DIGITS)) begin
                        n_dcount = r_dcount + 1'b1;
                    end
                end else begin
                    f_emit    = 1'b1;
                    f_tok     = num_tok;
                    run_start = 1'b1;
                end
            end
            M_LT, M_GT, M_EQ, M_BANG, M_PLUS, M_MINUS: begin
                f_emit = 1'b1;
                n_mode = M_START;
                if (i_char == p_second) begin
                    f_tok = simple_token(p_both);
                end else begin
                    f_tok     = simple_token(p_lone);
                    run_start = 1'b1;
                end
            end
            M_SLASH: begin
                if (i_char == CH_SLASH) begin
                    n_mode = M_LINE;
                end else if (i_char == CH_STAR) begin
                    n_mode = M_BLOCK;
                    n_star = 1'b0;
                end else begin
                    f_emit    = 1'b1;
                    f_tok     = simple_token(TK_SLASH);
                    run_start = 1'b1;
                end
            end
            M_LINE: begin
                if (i_char == CH_LF) begin
                    n_mode = M_START;
                end else if (i_char == CH_DOLLAR) begin
                    n_mode = M_START;
                    f_emit = 1'b1;
                    f_tok  = simple_token(TK_PERIOD);
                end
            end
            M_BLOCK: begin
                if (i_char == CH_DOLLAR) begin
                    n_mode = M_START;
                    n_star = 1'b0;
                    f_emit = 1'b1;
                    f_tok  = simple_token(TK_PERIOD);
                end else if (i_char == CH_STAR) begin
                    n_star = 1'b1;
                end else if (i_char == CH_SLASH && r_star) begin
                    n_mode = M_START;
                    n_star = 1'b0;
                end else begin
                    n_star = 1'b0;
                end
            end
            default: run_start = 1'b1;
        endcase

        if (run_start) begin
            n_mode = st_mode;
            if (st_mode == M_IDENT) begin
                n_ident_count = ICNT_W'(1);
                chr_we        = 1'b1;
                chr_idx       = '0;
            end
            if (st_mode == M_NUMBER) begin
                n_acc    = VALUE_W'(digit);
                n_dcount = DCNT_W'(1);
            end
        end
    end

    // order the tokens: a pending token goes out before the restarted scan
    always_comb begin
        o_toks = '0;
        if (f_emit) begin
            o_toks.tok0  = f_tok;
            o_toks.tok1  = st_tok;
            o_toks.count = (run_start && st_emit) ? 2'd2 : 2'd1;
        end else begin
            o_toks.tok0  = st_tok;
            o_toks.tok1  = st_tok;
            o_toks.count = (run_start && st_emit) ? 2'd1 : 2'd0;
        end
        o_toks.tok0.last = (o_toks.count == 2'd1);
        o_toks.tok1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= M_START;
            r_ident_count <= '0;
            r_acc         <= '0;
            r_dcount      <= '0;
            r_star        <= 1'b0;
        end else if (i_take) begin
            r_mode        <= n_mode;
            r_ident_count <= n_ident_count;
            r_acc         <= n_acc;
            r_dcount      <= n_dcount;
            r_star        <= n_star;
        end
    end

    // identifier characters hold no reset value
    always_ff @(posedge i_clk) begin
        if (i_take && chr_we) begin
            r_chars[chr_idx] <= i_char;
        end
    end

endmodule

FILE: src/pl0_token_scanner.sv
// ----------------------------------------------------------------------------
// pl0_token_scanner
// PL/0 lexer: one source character per transaction in, tokens out.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ---------------------------
//  char      in         i_char_valid / o_char_ready  i_char_code
//  token     out        o_tok_valid / i_tok_ready    o_token_code, o_number_value,
//                                                    o_number_too_long, o_ident_head,
//                                                    o_ident_tail, o_ident_length,
//                                                    o_last_of_run
//
//  one character is taken per cycle while o_char_ready is high; its tokens
//  are in the result register on the next cycle
//  a character that causes two tokens fills both result slots, so the char
//  channel holds while the first one drains
//  ready depends only on the result slot count and i_tok_ready
//  synchronous active-low reset returns the scanner to the start state with
//  nothing pending and empties the result slots
//
// ----------------------------------------------------------------------------
module pl0_token_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character channel
    input  logic        i_char_valid,
    output logic        o_char_ready,
    input  logic [7:0]  i_char_code,
    // token channel
    output logic        o_tok_valid,
    input  logic        i_tok_ready,
    output logic [5:0]  o_token_code,
    output logic [46:0] o_number_value,
    output logic        o_number_too_long,
    output logic [39:0] o_ident_head,
    output logic [39:0] o_ident_tail,
    output logic [3:0]  o_ident_length,
    output logic        o_last_of_run
);
    import pl0ts_pkg::*;

    t_tok_pair  toks;
    logic       push, pop;
    logic [1:0] r_cnt, n_cnt;
    t_token     r_q0, n_q0;
    t_token     r_q1, n_q1;

    // scanner state machine, advanced on each accepted character
    pl0ts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char_code),
        .i_take  (push),
        .o_toks  (toks)
    );

    // room for a new character once the slots will be empty after this edge
    assign o_char_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_tok_ready);
    assign push         = i_char_valid && o_char_ready;
    assign o_tok_valid  = (r_cnt != 2'd0);
    assign pop          = o_tok_valid && i_tok_ready;

    // two result slots, the head slot drives the ports
    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        if (pop) begin
            n_q0  = r_q1;
            n_cnt = r_cnt - 2'd1;
        end
        if (push) begin
            // both slots are free here
            n_q0  = toks.tok0;
            n_q1  = toks.tok1;
            n_cnt = toks.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // token payload needs no reset
    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_token_code      = r_q0.code;
    assign o_number_value    = r_q0.value;
    assign o_number_too_long = r_q0.too_long;
    assign o_ident_head      = r_q0.head;
    assign o_ident_tail      = r_q0.tail;
    assign o_ident_length    = r_q0.length;
    assign o_last_of_run     = r_q0.last;

endmodule

FILE: src/pl0ts_checker.sv
// ----------------------------------------------------------------------------
// pl0ts_checker
// Port-level checks for the PL/0 token scanner, bound to the top level.
// ----------------------------------------------------------------------------
module pl0ts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_char_valid,
    input logic        o_char_ready,
    input logic [7:0]  i_char_code,
    input logic        o_tok_valid,
    input logic        i_tok_ready,
    input logic [5:0]  o_token_code,
    input logic [46:0] o_number_value,
    input logic        o_number_too_long,
    input logic [3:0]  o_ident_length,
    input logic        o_last_of_run
);
    import pl0ts_pkg::*;

    // stalled token transaction holds
    a_tok_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_valid && !i_tok_ready |=> o_tok_valid && $stable(o_token_code))
        else $error("token dropped or changed while stalled");

    // end mark always causes at least one token
    a_end_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_char_valid && o_char_ready && i_char_code == CH_DOLLAR |=> o_tok_valid)
        else $error("end mark gave no token");

    // a token that is not last of its run is followed by another
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_valid && i_tok_ready && !o_last_of_run |=> o_tok_valid)
        else $error("second token of a run missing");

    a_ident_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_valid && o_ident_length != 4'd0 |->
            o_token_code == TK_IDENT && o_ident_length <= 4'(IDENT_MAX_CHARS))
        else $error("identifier length on wrong token");

    a_num_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_valid && o_number_too_long |->
            o_token_code == TK_NUMBER && o_number_value == NUM_SAT)
        else $error("too-long flag without saturated number");

endmodule

bind pl0_token_scanner pl0ts_checker u_pl0ts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_char_valid      (i_char_valid),
    .o_char_ready      (o_char_ready),
    .i_char_code       (i_char_code),
    .o_tok_valid       (o_tok_valid),
    .i_tok_ready       (i_tok_ready),
    .o_token_code      (o_token_code),
    .o_number_value    (o_number_value),
    .o_number_too_long (o_number_too_long),
    .o_ident_length    (o_ident_length),
    .o_last_of_run     (o_last_of_run)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PL/0 token scanner: characters go in over a
// valid/ready channel, each is run through a scan-state predictor, and every
// token that comes out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import pl0ts_pkg::*;

    localparam int RANDOM_ITEMS   = 2000;  // characters in the random part
    localparam int IDLE_PCT       = 12;    // gap chance %: per char in, per cycle out
    localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int DRAIN_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 20;    // settle time after the last token
    localparam int HALF_WORD      = 5;     // identifier characters per output word

    // scan states of the predictor
    typedef enum logic [3:0] {
        SC_IDLE, SC_WORD, SC_NUMBER, SC_LT, SC_GT, SC_EQ, SC_BANG, SC_SLASH,
        SC_PLUS, SC_MINUS, SC_LINE_CMT, SC_BLOCK_CMT
    } t_scan_state;

    // ------------------------------------------------------------------------
    // predictor and checker for the token stream
    // ------------------------------------------------------------------------
    class token_scoreboard;
        t_scan_state                state;
        logic [7:0]                 word_chars [IDENT_MAX_CHARS];
        logic [8*IDENT_MAX_CHARS-1:0] word_bits;   // right-justified, for keyword match
        int                         word_len;
        logic [VALUE_W-1:0]         num_acc;
        int                         num_digits;
        bit                         star_seen;
        logic [VALUE_W-1:0]         num_ceiling;
        t_token                     step_out [2];
        int                         step_n;
        t_token                     expected_tokens [$];
        int                         mismatches;
        int                         tokens_checked;
        int                         kind_count [64];

        function new();
            logic [63:0] p;
            p = 64'd1;
            for (int i = 0; i < NUMBER_MAX_DIGITS; i++) begin
                p = p * 64'd10;
            end
            num_ceiling    = VALUE_W'(p - 64'd1);
            state          = SC_IDLE;
            word_bits      = '0;
            word_len       = 0;
            num_acc        = '0;
            num_digits     = 0;
            star_seen      = 1'b0;
            mismatches     = 0;
            tokens_checked = 0;
            foreach (word_chars[i]) word_chars[i] = '0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function void add_token(logic [5:0] code, logic [VALUE_W-1:0] value,
                                logic too_long, logic [39:0] head,
                                logic [39:0] tail, logic [3:0] len);
            t_token t;
            t          = '0;
            t.code     = code;
            t.value    = value;
            t.too_long = too_long;
            t.head     = head;
            t.tail     = tail;
            t.length   = len;
            step_out[step_n] = t;
            step_n++;
        endfunction

        function void add_simple(logic [5:0] code);
            add_token(code, '0, 1'b0, '0, '0, '0);
        endfunction

        // keyword or identifier from the collected characters
        function void add_word();
            logic [5:0]  code;
            logic [39:0] head;
            logic [39:0] tail;
            bit          keyword;
            keyword = 1'b1;
            code    = TK_IDENT;
            case (word_bits)
                "call":   code = TK_CALL;
                "const":  code = TK_CONST;
                "else":   code = TK_ELSE;
                "for":    code = TK_FOR;
                "func":   code = TK_FUNC;
                "if":     code = TK_IF;
                "in":     code = TK_IN;
                "odd":    code = TK_ODD;
                "print":  code = TK_PRINT;
                "read":   code = TK_READ;
                "repeat": code = TK_REPEAT;
                "var":    code = TK_VAR;
                "while":  code = TK_WHILE;
                "char":   code = TK_CHAR;
                default:  keyword = 1'b0;
            endcase
            if (keyword) begin
                add_simple(code);
            end else begin
                head = '0;
                tail = '0;
                for (int i = 0; i < HALF_WORD; i++) begin
                    if (i < word_len) head[39-8*i -: 8] = word_chars[i];
                    if (i + HALF_WORD < word_len) tail[39-8*i -: 8] = word_chars[i+HALF_WORD];
                end
                add_token(TK_IDENT, '0, 1'b0, head, tail, 4'(word_len));
            end
        endfunction

        function void add_number();
            if (num_digits > NUMBER_MAX_DIGITS) begin
                add_token(TK_NUMBER, num_ceiling, 1'b1, '0, '0, '0);
            end else begin
                add_token(TK_NUMBER, num_acc, 1'b0, '0, '0, '0);
            end
        endfunction

        function void push_word_char(logic [7:0] c);
            if (word_len < IDENT_MAX_CHARS) begin
                word_chars[word_len] = c;
                word_bits = {word_bits[8*IDENT_MAX_CHARS-9:0], c};
                word_len++;
            end
        endfunction

        // character seen from the start state
        function void from_idle(logic [7:0] c);
            state = SC_IDLE;
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
                // whitespace, nothing to emit
            end else if (c == CH_DOLLAR) begin
                add_simple(TK_PERIOD);
            end else if (is_letter(c)) begin
                word_len  = 0;
                word_bits = '0;
                push_word_char(c);
                if (word_len >= IDENT_MAX_CHARS) add_word();
                else state = SC_WORD;
            end else if (is_digit(c)) begin
                num_acc    = VALUE_W'(c - CH_0);
                num_digits = 1;
                state      = SC_NUMBER;
            end else begin
                case (c)
                    CH_LT:      state = SC_LT;
                    CH_GT:      state = SC_GT;
                    CH_EQ:      state = SC_EQ;
                    CH_BANG:    state = SC_BANG;
                    CH_SLASH:   state = SC_SLASH;
                    CH_PLUS:    state = SC_PLUS;
                    CH_MINUS:   state = SC_MINUS;
                    CH_PERCENT: add_simple(TK_MOD);
                    CH_STAR:    add_simple(TK_TIMES);
                    CH_LPAREN:  add_simple(TK_LPAREN);
                    CH_RPAREN:  add_simple(TK_RPAREN);
                    CH_LBRACE:  add_simple(TK_LBRACE);
                    CH_RBRACE:  add_simple(TK_RBRACE);
                    CH_SEMI:    add_simple(TK_SEMI);
                    default:    add_simple(TK_NUL);
                endcase
            end
        endfunction

        // pending one-char operator: either completed or emitted alone
        function void pair_op(logic [7:0] c, logic [7:0] second,
                              logic [5:0] both, logic [5:0] lone);
            state = SC_IDLE;
            if (c == second) begin
                add_simple(both);
            end else begin
                add_simple(lone);
                from_idle(c);
            end
        endfunction

        // accepted character: predict its tokens
        function void note_char(logic [7:0] c);
            t_token t;
            step_n = 0;
            case (state)
                SC_WORD: begin
                    if (is_letter(c) || is_digit(c)) begin
                        push_word_char(c);
                        if (word_len >= IDENT_MAX_CHARS) begin
                            state = SC_IDLE;
                            add_word();
                        end
                    end else begin
                        add_word();
                        from_idle(c);
                    end
                end
                SC_NUMBER: begin
                    if (is_digit(c)) begin
                        if (num_digits < NUMBER_MAX_DIGITS)
                            num_acc = num_acc * 10 + VALUE_W'(c - CH_0);
                        if (num_digits <= NUMBER_MAX_DIGITS) num_digits++;
                    end else begin
                        add_number();
                        from_idle(c);
                    end
                end
                SC_LT:    pair_op(c, CH_EQ, TK_LEQ, TK_LSS);
                SC_GT:    pair_op(c, CH_EQ, TK_GEQ, TK_GTR);
                SC_EQ:    pair_op(c, CH_EQ, TK_EQL, TK_BECOMES);
                SC_BANG:  pair_op(c, CH_EQ, TK_NEQ, TK_NUL);
                SC_PLUS:  pair_op(c, CH_PLUS, TK_ADD, TK_PLUS);
                SC_MINUS: pair_op(c, CH_MINUS, TK_SUB, TK_MINUS);
                SC_SLASH: begin
                    if (c == CH_SLASH) begin
                        state = SC_LINE_CMT;
                    end else if (c == CH_STAR) begin
                        state     = SC_BLOCK_CMT;
                        star_seen = 1'b0;
                    end else begin
                        add_simple(TK_SLASH);
                        from_idle(c);
                    end
                end
                SC_LINE_CMT: begin
                    if (c == CH_LF) begin
                        state = SC_IDLE;
                    end else if (c == CH_DOLLAR) begin
                        state = SC_IDLE;
                        add_simple(TK_PERIOD);
                    end
                end
                SC_BLOCK_CMT: begin
                    if (c == CH_DOLLAR) begin
                        state     = SC_IDLE;
                        star_seen = 1'b0;
                        add_simple(TK_PERIOD);
                    end else if (c == CH_STAR) begin
                        star_seen = 1'b1;
                    end else if (c == CH_SLASH && star_seen) begin
                        state     = SC_IDLE;
                        star_seen = 1'b0;
                    end else begin
                        star_seen = 1'b0;
                    end
                end
                default: from_idle(c);
            endcase
            for (int i = 0; i < step_n; i++) begin
                t      = step_out[i];
                t.last = (i == step_n - 1);
                expected_tokens.insert(expected_tokens.size(), t);
            end
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        // accepted token: compare with the oldest prediction
        function void check_token(t_token got);
            t_token want;
            tokens_checked++;
            kind_count[got.code]++;
            if (expected_tokens.size() == 0) begin
                note_failure($sformatf("token %0d: unexpected, code %0d value %0d",
                                       tokens_checked, got.code, got.value));
            end else begin
                want = expected_tokens.pop_front();
                if (got.code !== want.code || got.value !== want.value ||
                    got.too_long !== want.too_long || got.head !== want.head ||
                    got.tail !== want.tail || got.length !== want.length ||
                    got.last !== want.last) begin
                    note_failure($sformatf(
                        "token %0d: expected code %0d value %0d long %0b head %h tail %h len %0d last %0b",
                        tokens_checked, want.code, want.value, want.too_long, want.head,
                        want.tail, want.length, want.last));
                    if (mismatches <= 10)
                        $display("          actual code %0d value %0d long %0b head %h tail %h len %0d last %0b",
                                 got.code, got.value, got.too_long, got.head, got.tail,
                                 got.length, got.last);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_char_valid = 1'b0;
    logic [7:0]  i_char_code  = '0;
    logic        i_tok_ready  = 1'b0;
    logic        o_char_ready;
    logic        o_tok_valid;
    logic [5:0]  o_token_code;
    logic [46:0] o_number_value;
    logic        o_number_too_long;
    logic [39:0] o_ident_head;
    logic [39:0] o_ident_tail;
    logic [3:0]  o_ident_length;
    logic        o_last_of_run;

    always #5 i_clk = ~i_clk;

    pl0_token_scanner i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_char_valid      (i_char_valid),
        .o_char_ready      (o_char_ready),
        .i_char_code       (i_char_code),
        .o_tok_valid       (o_tok_valid),
        .i_tok_ready       (i_tok_ready),
        .o_token_code      (o_token_code),
        .o_number_value    (o_number_value),
        .o_number_too_long (o_number_too_long),
        .o_ident_head      (o_ident_head),
        .o_ident_tail      (o_ident_tail),
        .o_ident_length    (o_ident_length),
        .o_last_of_run     (o_last_of_run)
    );

    token_scoreboard sb;
    logic [7:0]      char_queue [$];   // characters waiting to be driven
    int              chars_sent    = 0;
    int              random_chars  = 0;
    int              idle_cycles   = 0;
    bit              steady        = 1'b0;   // no gaps on either side while set
    bit              hold_request  = 1'b0;   // asks the receiver for a long hold-off

    string keywords [14] = '{"call", "const", "else", "for", "func", "if", "in",
                             "odd", "print", "read", "repeat", "var", "while", "char"};
    string op_texts [22] = '{"+", "-", "*", "/", "%", "(", ")", "{", "}", ";", "<",
                             "<=", ">", ">=", "=", "==", "!=", "!", "++", "--",
                             "+-", "<<"};

    // ------------------------------------------------------------------------
    // character source
    // ------------------------------------------------------------------------
    function automatic void queue_char(logic [7:0] c);
        char_queue.insert(char_queue.size(), c);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    endfunction

    function automatic logic [7:0] random_letter();
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] random_digit();
        return CH_0 + 8'($urandom_range(9));
    endfunction

    // one fragment of source text: mostly well-formed lexemes, some noise
    function automatic void add_fragment();
        int pick;
        int n;
        int start_n;
        start_n = char_queue.size();
        pick    = $urandom_range(99);
        if (pick < 18) begin
            // keyword, now and then with a letter glued on so it turns into a name
            add_text(keywords[$urandom_range(13)]);
            if ($urandom_range(7) == 0) queue_char(random_letter());
        end else if (pick < 36) begin
            // identifier, a few past the length limit
            n = $urandom_range(1, 12);
            queue_char(random_letter());
            for (int i = 1; i < n; i++)
                queue_char($urandom_range(3) == 0 ? random_digit() : random_letter());
        end else if (pick < 51) begin
            // number, mostly short, sometimes over the digit limit
            n = ($urandom_range(9) == 0) ? $urandom_range(13, 17) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++) queue_char(random_digit());
        end else if (pick < 73) begin
            add_text(op_texts[$urandom_range(21)]);
        end else if (pick < 81) begin
            case ($urandom_range(2))
                0:       queue_char(CH_SPACE);
                1:       queue_char(CH_TAB);
                default: queue_char(CH_LF);
            endcase
        end else if (pick < 87) begin
            // line comment, sometimes cut short by the end mark
            add_text("//");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) queue_char(8'($urandom_range(32, 126)));
            queue_char($urandom_range(5) == 0 ? CH_DOLLAR : CH_LF);
        end else if (pick < 93) begin
            // block comment with stars and slashes inside
            add_text("/*");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(4))
                    0:       queue_char(CH_STAR);
                    1:       queue_char(CH_SLASH);
                    2:       queue_char(CH_LF);
                    3:       queue_char(CH_SPACE);
                    default: queue_char(random_letter());
                endcase
            end
            if ($urandom_range(7) == 0) queue_char(CH_DOLLAR);
            else add_text("*/");
        end else begin
            // raw bytes over the whole range
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) queue_char(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 55) queue_char(CH_SPACE);
        // every generated character counts toward the random total
        random_chars += char_queue.size() - start_n;
    endfunction

    // ------------------------------------------------------------------------
    // character channel driver
    // ------------------------------------------------------------------------
    // one transaction: drive at the falling edge, accept at the rising edge
    task automatic send_char(input logic [7:0] c);
        int gap;
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_char_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
        end
        i_char_valid <= 1'b1;
        i_char_code  <= c;
        @(posedge i_clk);
        while (!o_char_ready) @(posedge i_clk);
        sb.note_char(c);
        chars_sent++;
    endtask

    task automatic send_queued();
        while (char_queue.size() > 0) send_char(char_queue.pop_front());
    endtask

    // stop offering and wait for every predicted token to come out
    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_char_valid <= 1'b0;
        while (sb.expected_tokens.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // ------------------------------------------------------------------------
    // token channel: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin : token_sink
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_tok_ready <= 1'b0;
                // the sender keeps going, so the result slots fill and input stalls
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_tok_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // every accepted token is checked against the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && o_tok_valid && i_tok_ready)
            sb.check_token({o_token_code, o_number_value, o_number_too_long,
                            o_ident_head, o_ident_tail, o_ident_length, o_last_of_run});
    end

    // watchdog: no transaction on either channel for too long
    always @(posedge i_clk) begin
        if ((i_char_valid && o_char_ready) || (o_tok_valid && i_tok_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("pl0_token_scanner test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int  failures;
        int  kinds;
        bit  hold_done;
        bit  drain_done;
        sb         = new();
        hold_done  = 1'b0;
        drain_done = 1'b0;

        // reset, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identifier at full length, over-long number, lone bang and
        // slash, every two-char comparison, opening star not closing a comment,
        // end mark inside both comment kinds, unknown bytes
        add_text("Az09abcdefG1 ");
        add_text("999999999999999 0;");
        add_text("!x/y<=>=!===<>");
        add_text("/*/**/");
        add_text("//a$");
        add_text("/*$");
        queue_char(8'h00);
        queue_char(8'h0D);
        queue_char(8'h80);
        queue_char(8'hFF);
        add_text(",.:\t\n");
        send_queued();

        // random source text
        while (random_chars < RANDOM_ITEMS) begin
            add_fragment();
            if (!hold_done && random_chars >= 400) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && random_chars >= 1300) begin
                wait_drained();
                drain_done = 1'b1;
            end
            steady = (random_chars >= 800 && random_chars < 1100);
            send_queued();
        end

        // end mark flushes whatever token is still pending
        add_text("$");
        send_queued();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        failures = sb.mismatches + sb.expected_tokens.size();
        if (sb.expected_tokens.size() > 0)
            $display("%0d predicted tokens never arrived", sb.expected_tokens.size());
        kinds = 0;
        foreach (sb.kind_count[k]) begin
            if (sb.kind_count[k] > 0) kinds++;
        end
        $display("summary: %0d characters scanned, %0d tokens checked, %0d of 37 token kinds",
                 chars_sent, sb.tokens_checked, kinds);
        $display("summary: %0d-cycle receiver hold-off and a full drain pause, %0d mismatches",
                 HOLD_CYCLES, sb.mismatches);
        if (failures == 0) begin
            $display("pl0_token_scanner test passed");
        end else begin
            $display("pl0_token_scanner test failed");
        end
        $finish;
    end

endmodule
